### design/scpa_pkg.sv
// Shared types, constants and class tables for the size class pool allocator.
// No dependencies; every other design file imports this package.
package scpa_pkg;

  // Pool geometry.
  localparam int POOL_GRANULES = 65536;
  localparam int NUM_CLASSES   = 9;
  localparam int GRANULE_BYTES = 32;
  localparam int TABLE_LEN     = 9;
  localparam int CLASS_LIM     = (NUM_CLASSES < TABLE_LEN) ? NUM_CLASSES : TABLE_LEN;

  // Field widths.
  localparam int SIZE_W  = 24;
  localparam int OFF_W   = 21;
  localparam int CAP_W   = 22;
  localparam int HDR_W   = 5;
  localparam int TOT_W   = 22;
  localparam int BYTES_W = 24;

  // Derived widths.
  localparam int GSHIFT  = $clog2(GRANULE_BYTES);
  localparam int GIDX_W  = $clog2(POOL_GRANULES);
  localparam int BUMP_W  = GIDX_W + 1;
  localparam int CLS_W   = $clog2(TABLE_LEN);
  localparam int GRN_W   = BYTES_W - GSHIFT;
  localparam int NEED_W  = SIZE_W + 1;
  localparam int BSUM_W  = ((GRN_W > BUMP_W) ? GRN_W : BUMP_W) + 1;
  localparam int CSUM_W  = (((BUMP_W + GSHIFT) > BYTES_W) ? (BUMP_W + GSHIFT) : BYTES_W) + 1;
  localparam int ASUM_W  = ((BYTES_W > TOT_W) ? BYTES_W : TOT_W) + 1;
  localparam int GCMP_W  = (OFF_W > BUMP_W) ? OFF_W : BUMP_W;
  localparam int LINK_W  = GIDX_W + 1;

  // Configuration port.
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int CAP_RESET  = 2097152;
  localparam int HDR_RESET  = 16;
  localparam logic REG_POOL_CAP = 1'b0;
  localparam logic REG_HEADER   = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_OVERSIZE  = 2'd2
  } status_t;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  block_offset;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [OFF_W-1:0] payload_offset;
    logic [TOT_W-1:0] allocated_bytes;
  } rsp_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_COMMIT
  } state_t;

  // What the lookup cycle decided to do with the request.
  typedef enum logic [2:0] {
    K_POP,
    K_CARVE,
    K_OVER,
    K_EXH,
    K_FREE,
    K_IGN
  } kind_t;

  typedef struct packed {
    logic capture;
    logic look;
    logic commit;
  } cmd_t;

  function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
    logic [BYTES_W-1:0] b;
    case (c)
      4'd0:    b = BYTES_W'(32);
      4'd1:    b = BYTES_W'(128);
      4'd2:    b = BYTES_W'(512);
      4'd3:    b = BYTES_W'(1024);
      4'd4:    b = BYTES_W'(2048);
      4'd5:    b = BYTES_W'(8192);
      4'd6:    b = BYTES_W'(1 * 1024 * 1024);
      4'd7:    b = BYTES_W'(4 * 1024 * 1024);
      4'd8:    b = BYTES_W'(8 * 1024 * 1024);
      default: b = BYTES_W'(32);
    endcase
    return b;
  endfunction

  function automatic logic [GRN_W-1:0] class_gran(input logic [CLS_W-1:0] c);
    logic [BYTES_W-1:0] b;
    b = class_bytes(c);
    return b[BYTES_W-1:GSHIFT];
  endfunction

endpackage

### design/size_class_pool_allocator.sv
// A request is captured, looked up and then committed to the output register;
// the link and block class memories are read in the lookup cycle and the stack
// heads are updated in the commit cycle.
// A new request is taken in the commit cycle of the one before it, and only when
// the output register is empty or its beat is taken in that cycle.
// Reset (rst_n, synchronous, active low) empties all class stacks, clears the
// bump pointer and byte count and restores the registers; memories are not swept.
module size_class_pool_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  scpa_pkg::req_t                in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output scpa_pkg::rsp_t                out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [scpa_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [scpa_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [scpa_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import scpa_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic [HDR_W-1:0] hdr_r;
  logic             cfg_wr;
  cmd_t             cmd;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(CAP_RESET);
      hdr_r <= HDR_W'(HDR_RESET);
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_POOL_CAP: cap_r <= cfg_pwdata[CAP_W-1:0];
        REG_HEADER:   hdr_r <= cfg_pwdata[HDR_W-1:0];
        default:      cap_r <= cap_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_POOL_CAP: cfg_prdata = CFG_DW'(cap_r);
      REG_HEADER:   cfg_prdata = CFG_DW'(hdr_r);
      default:      cfg_prdata = '0;
    endcase
  end

  scpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  scpa_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_cap  (cap_r),
    .cfg_hdr  (hdr_r),
    .out_data (out_data)
  );

endmodule

### design/scpa_ctrl.sv
// Request sequencer for the pool allocator: capture, lookup, commit.
// Depends on scpa_pkg; drives the datapath through a command struct.
module scpa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output scpa_pkg::cmd_t cmd
);
  import scpa_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    can_commit  = !out_valid_r || out_ready;
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // The next request may enter in the same cycle that this one retires.
        if (can_commit) begin
          cmd.commit = 1'b1;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_LOOK;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### design/scpa_dp.sv
// Datapath for the pool allocator: class selection, free stacks, link and
// class memories, bump pointer and byte count. Depends on scpa_pkg.
module scpa_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  scpa_pkg::cmd_t               cmd,
  input  scpa_pkg::req_t               in_data,
  input  logic [scpa_pkg::CAP_W-1:0]   cfg_cap,
  input  logic [scpa_pkg::HDR_W-1:0]   cfg_hdr,
  output scpa_pkg::rsp_t               out_data
);
  import scpa_pkg::*;

  // Link store and block class store; contents are undefined until written.
  logic [LINK_W-1:0] link_mem [POOL_GRANULES];
  logic [CLS_W-1:0]  cls_mem  [POOL_GRANULES];

  // Free stack heads, one per class.
  logic              head_vld_r [CLASS_LIM];
  logic [GIDX_W-1:0] head_idx_r [CLASS_LIM];

  req_t              req_r;
  logic [BUMP_W-1:0] bump_r;
  logic [TOT_W-1:0]  total_r;
  kind_t             kind_r;
  logic [CLS_W-1:0]  cls_r;
  logic [GIDX_W-1:0] blk_r;
  logic [LINK_W-1:0] link_rd_r;
  logic [CLS_W-1:0]  cls_rd_r;
  rsp_t              out_r;

  // Lookup cycle.
  logic [NEED_W-1:0] need;
  logic [CLS_W-1:0]  sel_cls;
  logic              fits_any;
  logic              sel_vld;
  logic [GIDX_W-1:0] sel_idx;
  logic [CSUM_W-1:0] cap_sum;
  logic [BSUM_W-1:0] look_bsum;
  logic              carve_ok;
  logic [OFF_W-1:0]  rel;
  logic [GCMP_W-1:0] g_full;
  logic              free_ok;
  kind_t             kind_nxt;
  logic [GIDX_W-1:0] blk_nxt;

  // Commit cycle.
  logic [CLS_W-1:0]   fcls;
  logic [CLS_W-1:0]   ccls;
  logic [BYTES_W-1:0] cbytes;
  logic [ASUM_W-1:0]  tsum;
  logic [TOT_W-1:0]   total_add;
  logic [TOT_W-1:0]   total_sub;
  logic [BSUM_W-1:0]  com_bsum;
  logic [OFF_W-1:0]   grant_off;
  rsp_t               rsp_nxt;

  always_comb begin
    need     = NEED_W'(req_r.request_size) + NEED_W'(cfg_hdr);
    sel_cls  = '0;
    fits_any = 1'b0;
    // Walk from the largest class down so the smallest fitting class wins.
    for (int i = CLASS_LIM - 1; i >= 0; i--) begin
      if (need <= NEED_W'(class_bytes(CLS_W'(i)))) begin
        sel_cls  = CLS_W'(i);
        fits_any = 1'b1;
      end
    end
    sel_vld = head_vld_r[sel_cls];
    sel_idx = head_idx_r[sel_cls];

    cap_sum   = CSUM_W'({bump_r, {GSHIFT{1'b0}}}) + CSUM_W'(class_bytes(sel_cls));
    look_bsum = BSUM_W'(bump_r) + BSUM_W'(class_gran(sel_cls));
    carve_ok  = (CSUM_W'(cfg_cap) >= cap_sum) && (look_bsum <= BSUM_W'(POOL_GRANULES));

    rel     = req_r.block_offset - OFF_W'(cfg_hdr);
    g_full  = GCMP_W'(rel >> GSHIFT);
    free_ok = (req_r.block_offset >= OFF_W'(cfg_hdr)) && (rel[GSHIFT-1:0] == '0) &&
              (g_full < GCMP_W'(bump_r));

    if (req_r.req_type == REQ_FREE) begin
      kind_nxt = free_ok ? K_FREE : K_IGN;
      blk_nxt  = g_full[GIDX_W-1:0];
    end else begin
      blk_nxt = sel_vld ? sel_idx : bump_r[GIDX_W-1:0];
      if (!fits_any) begin
        kind_nxt = K_OVER;
      end else if (sel_vld) begin
        kind_nxt = K_POP;
      end else if (carve_ok) begin
        kind_nxt = K_CARVE;
      end else begin
        kind_nxt = K_EXH;
      end
    end
  end

  always_comb begin
    // A stored class code past the table counts as the smallest class.
    fcls   = (cls_rd_r >= CLS_W'(CLASS_LIM)) ? '0 : cls_rd_r;
    ccls   = (kind_r == K_FREE) ? fcls : cls_r;
    cbytes = class_bytes(ccls);

    tsum      = ASUM_W'(total_r) + ASUM_W'(cbytes);
    total_add = (tsum > ASUM_W'({TOT_W{1'b1}})) ? {TOT_W{1'b1}} : TOT_W'(tsum);
    total_sub = (ASUM_W'(total_r) >= ASUM_W'(cbytes)) ?
                TOT_W'(ASUM_W'(total_r) - ASUM_W'(cbytes)) : '0;

    com_bsum  = BSUM_W'(bump_r) + BSUM_W'(class_gran(cls_r));
    grant_off = OFF_W'({blk_r, {GSHIFT{1'b0}}}) + OFF_W'(cfg_hdr);

    rsp_nxt.status          = STAT_OK;
    rsp_nxt.payload_offset  = '0;
    rsp_nxt.allocated_bytes = total_r;
    case (kind_r)
      K_POP, K_CARVE: begin
        rsp_nxt.payload_offset  = grant_off;
        rsp_nxt.allocated_bytes = total_add;
      end
      K_OVER:  rsp_nxt.status = STAT_OVERSIZE;
      K_EXH:   rsp_nxt.status = STAT_EXHAUSTED;
      K_FREE:  rsp_nxt.allocated_bytes = total_sub;
      K_IGN:   rsp_nxt.status = STAT_OK;
      default: rsp_nxt.status = STAT_OK;
    endcase
  end

  // Request capture, lookup results and output register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.look) begin
      kind_r <= kind_nxt;
      cls_r  <= sel_cls;
      blk_r  <= blk_nxt;
    end
    if (cmd.commit) begin
      out_r <= rsp_nxt;
    end
  end

  // Memories: read during lookup, written at commit.
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      link_rd_r <= link_mem[sel_idx];
      cls_rd_r  <= cls_mem[g_full[GIDX_W-1:0]];
    end
    if (cmd.commit && kind_r == K_FREE) begin
      link_mem[blk_r] <= {head_vld_r[fcls], head_idx_r[fcls]};
    end
    if (cmd.commit && kind_r == K_CARVE) begin
      cls_mem[blk_r] <= cls_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bump_r  <= '0;
      total_r <= '0;
      for (int i = 0; i < CLASS_LIM; i++) begin
        head_vld_r[i] <= 1'b0;
      end
    end else if (cmd.commit) begin
      total_r <= rsp_nxt.allocated_bytes;
      if (kind_r == K_CARVE) begin
        bump_r <= BUMP_W'(com_bsum);
      end
      for (int i = 0; i < CLASS_LIM; i++) begin
        if (kind_r == K_POP && cls_r == CLS_W'(i)) begin
          head_vld_r[i] <= link_rd_r[LINK_W-1];
        end else if (kind_r == K_FREE && fcls == CLS_W'(i)) begin
          head_vld_r[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < CLASS_LIM; i++) begin
        if (kind_r == K_POP && cls_r == CLS_W'(i)) begin
          head_idx_r[i] <= link_rd_r[GIDX_W-1:0];
        end else if (kind_r == K_FREE && fcls == CLS_W'(i)) begin
          head_idx_r[i] <= blk_r;
        end
      end
    end
  end

  assign out_data = out_r;

endmodule

### verif/scpa_checker.sv
`timescale 1ns / 1ps
// Checker for the size class pool allocator: keeps its own copy of the pool state,
// predicts each result from the request and register beats and compares it.
// Depends on scpa_pkg.
module scpa_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  scpa_pkg::req_t              in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  scpa_pkg::rsp_t              out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic                        cfg_pready,
  input  logic [scpa_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [scpa_pkg::CFG_DW-1:0] cfg_pwdata,
  output int                          errors,
  output int                          open_replies
);
  import scpa_pkg::*;

  localparam longint TOTAL_MAX = (longint'(1) << TOT_W) - 1;

  logic [CAP_W-1:0]  pool_cap;
  logic [HDR_W-1:0]  hdr_len;
  logic [BUMP_W-1:0] bump_next;
  logic [TOT_W-1:0]  bytes_out;
  logic [LINK_W-1:0] stack_top [TABLE_LEN];
  logic [LINK_W-1:0] next_free [POOL_GRANULES];
  logic [3:0]        carved_cls [POOL_GRANULES];
  rsp_t              due_q [$];

  function automatic int unsigned class_size(input int c);
    case (c)
      0:       return 32;
      1:       return 128;
      2:       return 512;
      3:       return 1024;
      4:       return 2048;
      5:       return 8192;
      6:       return 1 << 20;
      7:       return 4 << 20;
      default: return 8 << 20;
    endcase
  endfunction

  // Applies one request to the pool copy and returns the result it should produce.
  task automatic apply_request(input req_t rq, output rsp_t rs);
    longint          need;
    longint          sum;
    int              c;
    int              blk;
    int              g;
    int unsigned     bytes;
    logic [OFF_W-1:0] rel;
    rs.status         = STAT_OK;
    rs.payload_offset = '0;
    if (rq.req_type == REQ_FREE) begin
      if (rq.block_offset >= hdr_len) begin
        rel = rq.block_offset - hdr_len;
        g   = int'(rel >> GSHIFT);
        if (rel[GSHIFT-1:0] == '0 && g < bump_next) begin
          c = carved_cls[g];
          if (c >= CLASS_LIM) c = 0;
          bytes     = class_size(c);
          bytes_out = (bytes_out >= bytes) ? bytes_out - TOT_W'(bytes) : '0;
          next_free[g] = stack_top[c];
          stack_top[c] = {1'b1, GIDX_W'(g)};
        end
      end
    end else begin
      need = longint'(rq.request_size) + hdr_len;
      c = 0;
      while (c < CLASS_LIM && need > class_size(c)) c++;
      if (c >= CLASS_LIM) begin
        rs.status = STAT_OVERSIZE;
      end else begin
        bytes = class_size(c);
        blk   = 0;
        if (stack_top[c][LINK_W-1]) begin
          blk          = int'(stack_top[c][GIDX_W-1:0]);
          stack_top[c] = next_free[blk];
        end else if (longint'(pool_cap) >= longint'(bump_next) * GRANULE_BYTES + bytes &&
                     longint'(bump_next) + bytes / GRANULE_BYTES <= POOL_GRANULES) begin
          blk             = int'(bump_next);
          carved_cls[blk] = 4'(c);
          bump_next       = bump_next + BUMP_W'(bytes / GRANULE_BYTES);
        end else begin
          rs.status = STAT_EXHAUSTED;
        end
        if (rs.status == STAT_OK) begin
          sum               = longint'(bytes_out) + bytes;
          bytes_out         = (sum > TOTAL_MAX) ? TOT_W'(TOTAL_MAX) : TOT_W'(sum);
          rs.payload_offset = OFF_W'(longint'(blk) * GRANULE_BYTES + hdr_len);
        end
      end
    end
    rs.allocated_bytes = bytes_out;
  endtask

  always @(posedge clk) begin : track
    rsp_t want;
    if (!rst_n) begin
      pool_cap  = CAP_W'(CAP_RESET);
      hdr_len   = HDR_W'(HDR_RESET);
      bump_next = '0;
      bytes_out = '0;
      for (int i = 0; i < TABLE_LEN; i++) stack_top[i] = '0;
      due_q.delete();
      errors = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if ((cfg_paddr >> 2) == CFG_AW'(REG_POOL_CAP)) pool_cap = cfg_pwdata[CAP_W-1:0];
        else if ((cfg_paddr >> 2) == CFG_AW'(REG_HEADER)) hdr_len = cfg_pwdata[HDR_W-1:0];
      end
      // The result beat of this edge is always older than a request beat of the same edge.
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $error("result beat with no result expected");
          errors++;
        end else begin
          want = due_q.pop_front();
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.payload_offset !== want.payload_offset) begin
            $error("payload_offset mismatch: expected %0d, got %0d",
                   want.payload_offset, out_data.payload_offset);
            errors++;
          end
          if (out_data.allocated_bytes !== want.allocated_bytes) begin
            $error("allocated_bytes mismatch: expected %0d, got %0d",
                   want.allocated_bytes, out_data.allocated_bytes);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_request(in_data, want);
        due_q.push_back(want);
      end
    end
    open_replies = due_q.size();
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for the size class pool allocator: drives requests, register writes and
// result stalls, and gives the verdict. Depends on the allocator, scpa_pkg and scpa_checker.
module tb;
  import scpa_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam logic [CFG_AW-1:0] CAP_ADDR = CFG_AW'(4 * int'(REG_POOL_CAP));
  localparam logic [CFG_AW-1:0] HDR_ADDR = CFG_AW'(4 * int'(REG_HEADER));

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  req_t              in_data     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  rsp_t              out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                errors;
  int                open_replies;

  // What the request side knows about the pool, learned from result beats.
  req_t inflight_q [$];
  int   sent_cnt   = 0;
  int   done_cnt   = 0;
  int   live_q [$];
  int   start_q [$];
  bit   is_start [int];
  int   carve_end  = 0;
  int   mega_blk   = -1;
  int   hdr_now    = HDR_RESET;
  int   calm_items = 0;
  int   stall_left = 0;
  int   calm_left  = 0;
  int   idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  size_class_pool_allocator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  scpa_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_pready   (cfg_pready),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .errors       (errors),
    .open_replies (open_replies)
  );

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic int class_of(input int unsigned size);
    int c = 0;
    while (c < CLASS_LIM && longint'(size) + hdr_now > class_bytes(CLS_W'(c))) c++;
    return c;
  endfunction

  // Mostly sizes that land in the small classes, with the exact class boundary now and then.
  function automatic int unsigned pick_size();
    int     r = $urandom_range(0, 99);
    int     c;
    int     lo;
    int     hi;
    longint need;
    if (r < 20) c = 0;
    else if (r < 40) c = 1;
    else if (r < 55) c = 2;
    else if (r < 68) c = 3;
    else if (r < 80) c = 4;
    else if (r < 92) c = 5;
    else if (r < 96) c = 6;
    else c = $urandom_range(7, 8);
    hi   = int'(class_bytes(CLS_W'(c)));
    lo   = (c == 0) ? 0 : int'(class_bytes(CLS_W'(c - 1))) + 1;
    need = ($urandom_range(0, 7) == 0) ? hi : $urandom_range(lo, hi);
    return (need > hdr_now) ? int'(need - hdr_now) : 0;
  endfunction

  function automatic req_t alloc_req(input int unsigned size);
    req_t rq;
    rq.req_type     = REQ_ALLOC;
    rq.request_size = SIZE_W'(size);
    rq.block_offset = OFF_W'($urandom);
    return rq;
  endfunction

  function automatic req_t free_req(input int unsigned off);
    req_t rq;
    rq.req_type     = REQ_FREE;
    rq.request_size = SIZE_W'($urandom);
    rq.block_offset = OFF_W'(off);
    return rq;
  endfunction

  task automatic push_request(input req_t rq);
    int gap;
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (!in_ready);
    inflight_q.push_back(rq);
    sent_cnt++;
    gap = (calm_items > 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sent_cnt != done_cnt) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned cap, input int hdr);
    wait_drained();
    cfg_write(CAP_ADDR, cap);
    cfg_write(HDR_ADDR, hdr);
    hdr_now = hdr;
  endtask

  task automatic random_item();
    req_t rq;
    int   pick;
    int   idx;
    int   g;
    int unsigned off;
    pick = $urandom_range(0, 99);
    if (live_q.size() > 40) pick = 60;
    if (pick >= 50 && pick < 84 && live_q.size() > 0) begin
      idx = $urandom_range(0, live_q.size() - 1);
      g   = live_q[idx];
      live_q.delete(idx);
      rq = free_req(g * GRANULE_BYTES + hdr_now);
    end else if (pick >= 84 && pick < 88 && start_q.size() > 0) begin
      // Any known block start may be freed again; if it is already on a stack, the stack then holds it twice.
      g  = start_q[$urandom_range(0, start_q.size() - 1)];
      rq = free_req(g * GRANULE_BYTES + hdr_now);
    end else if (pick >= 88 && pick < 94) begin
      off = $urandom_range(0, (1 << OFF_W) - 1);
      if (hdr_now > 0 && $urandom_range(0, 3) == 0) off = $urandom_range(0, hdr_now - 1);
      // Moving an aligned offset by one makes it unusable without touching any block.
      if (off >= hdr_now && (off - hdr_now) % GRANULE_BYTES == 0) off = off ^ 1;
      rq = free_req(off);
    end else if (pick >= 94 && pick < 97 && sent_cnt == done_cnt && carve_end < POOL_GRANULES)
    begin
      g  = $urandom_range(carve_end, POOL_GRANULES - 1);
      rq = free_req(g * GRANULE_BYTES + hdr_now);
    end else if (pick >= 97) begin
      rq = alloc_req($urandom);
    end else begin
      rq = alloc_req(pick_size());
    end
    push_request(rq);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (calm_items > 0) calm_items--;
      else if ($urandom_range(0, 99) == 0) calm_items = $urandom_range(20, 80);
      random_item();
    end
  endtask

  task automatic directed_run();
    // Requests for each carvable class, mostly at its upper boundary, then the never carvable
    // classes and the oversized requests.
    push_request(alloc_req(0));
    push_request(alloc_req(16));
    push_request(alloc_req(17));
    push_request(alloc_req(496));
    push_request(alloc_req(1008));
    push_request(alloc_req(2032));
    push_request(alloc_req(8176));
    push_request(alloc_req(1048560));
    push_request(alloc_req(1048561));
    push_request(alloc_req(8388592));
    push_request(alloc_req(8388593));
    push_request(alloc_req((1 << SIZE_W) - 1));
    // Unusable offsets: below the header, off the granule grid, past the bump pointer.
    push_request(free_req(0));
    push_request(free_req(hdr_now + 1));
    push_request(free_req((POOL_GRANULES - 1) * GRANULE_BYTES + hdr_now));
    wait_drained();
    if (mega_blk >= 0) begin
      // Freeing the large block repeatedly drives the byte count to zero, and
      // popping it back as often pushes the count to its ceiling.
      repeat (5) push_request(free_req(mega_blk * GRANULE_BYTES + hdr_now));
      repeat (5) push_request(alloc_req(1048560));
    end
  endtask

  always @(posedge clk) begin
    if (calm_left > 0) begin
      calm_left--;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 300);
      else if ($urandom_range(0, 2) == 0) stall_left = gap_len();
    end
  end

  // Learns block starts and the carved extent from granted results.
  always @(posedge clk) begin : watch_results
    req_t rq;
    int   diff;
    int   g;
    int   cls;
    if (rst_n && out_valid && out_ready && inflight_q.size() > 0) begin
      rq = inflight_q.pop_front();
      if (rq.req_type == REQ_ALLOC && out_data.status == STAT_OK) begin
        diff = int'(out_data.payload_offset) - hdr_now;
        if (diff >= 0) begin
          g   = diff / GRANULE_BYTES;
          cls = class_of(rq.request_size);
          live_q.push_back(g);
          if (!is_start.exists(g)) begin
            is_start[g] = 1'b1;
            start_q.push_back(g);
          end
          if (cls == 6) mega_blk = g;
          if (cls < CLASS_LIM && g + int'(class_gran(CLS_W'(cls))) > carve_end)
            carve_end = g + int'(class_gran(CLS_W'(cls)));
        end
      end
      done_cnt++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_run();
    set_config(2097152, 0);
    run_random(500);
    // With no room to carve, only blocks already on the stacks can be granted.
    set_config(0, 31);
    run_random(200);
    set_config($urandom_range(carve_end * GRANULE_BYTES, 2097152), $urandom_range(1, 30));
    run_random(280);
    wait_drained();
    run_random(280);
    set_config(2097152, 16);
    run_random(450);
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && open_replies == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
design/scpa_pkg.sv
design/scpa_ctrl.sv
design/scpa_dp.sv
design/size_class_pool_allocator.sv
verif/scpa_checker.sv
verif/tb.sv
